@@ design/lbh_pkg.sv @@
`default_nettype none

package lbh_pkg;

   localparam logic [31:0] GOLDEN      = 32'h9e3779b9;
   localparam int          BLOCK_BYTES = 12;
   localparam logic [3:0]  LAST_SLOT   = 4'(BLOCK_BYTES - 1);
   localparam logic [3:0]  LAST_STEP   = 4'd8;

   typedef enum logic [1:0] {
      JOB_BLOCK      = 2'd0,
      JOB_TAIL       = 2'd1,
      JOB_BLOCK_TAIL = 2'd2
   } job_kind_type;

   typedef struct packed {
      logic         start;
      job_kind_type kind;
      logic [31:0]  word_a;
      logic [31:0]  word_b;
      logic [31:0]  word_c;
      logic [31:0]  length;
   } job_type;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_MIX  = 4'b0010,
      ST_LEN  = 4'b0100,
      ST_EMIT = 4'b1000
   } back_state_type;

endpackage

`default_nettype wire

@@ design/lbh_front.sv @@
`default_nettype none

module lbh_front
   import lbh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // data_byte
   input  wire logic       req_tlast,   // last_byte
   input  wire logic       q_full,
   output logic            q_push,
   output job_type         q_job
);

   logic        busy_ff, busy_in;
   logic [3:0]  pos_ff, pos_in;
   logic [95:0] buf_ff, buf_in;
   logic [31:0] total_ff, total_in;

   logic [95:0] buf_with;
   logic [31:0] len_next;
   logic        accept, full;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign len_next   = total_ff + 32'd1;
   assign full       = (pos_ff == LAST_SLOT);

   always_comb begin
      buf_with = buf_ff;
      buf_with[{pos_ff, 3'b000} +: 8] = req_tdata;
   end

   always_comb begin
      q_push        = accept && (full || req_tlast);
      q_job.start   = !busy_ff;
      q_job.kind    = full ? (req_tlast ? JOB_BLOCK_TAIL : JOB_BLOCK) : JOB_TAIL;
      q_job.word_a  = buf_with[31:0];
      q_job.word_b  = buf_with[63:32];
      q_job.word_c  = full ? buf_with[95:64] : len_next + {buf_with[87:64], 8'h00};
      q_job.length  = len_next;
   end

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      buf_in   = buf_ff;
      total_in = total_ff;
      if (accept) begin
         busy_in  = q_push ? !req_tlast : busy_ff;
         pos_in   = (full || req_tlast) ? 4'd0 : pos_ff + 4'd1;
         buf_in   = q_push ? 96'd0 : buf_with;
         total_in = req_tlast ? 32'd0 : len_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pos_ff   <= 4'd0;
         buf_ff   <= 96'd0;
         total_ff <= 32'd0;
      end else begin
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
         buf_ff   <= buf_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

@@ design/lbh_queue.sv @@
`default_nettype none

module lbh_queue
   import lbh_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output job_type   head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ design/lbh_back.sv @@
`default_nettype none

module lbh_back
   import lbh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] init_value,
   input  wire logic        q_valid,
   input  job_type          q_job,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata     // hash_out
);

   back_state_type state_ff, state_in;
   logic [31:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [3:0]     step_ff, step_in;
   job_kind_type   kind_ff, kind_in;
   logic [31:0]    len_ff, len_in;
   logic           second_ff, second_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_data_ff, rsp_data_in;

   logic [31:0] base_a, base_b, base_c;
   logic [31:0] a_sub, b_sub, c_sub;
   logic        out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign q_pop      = (state_ff == ST_LOAD) && q_valid;

   assign base_a = q_job.start ? GOLDEN : a_ff;
   assign base_b = q_job.start ? GOLDEN : b_ff;
   assign base_c = q_job.start ? init_value : c_ff;

   assign a_sub = a_ff - b_ff - c_ff;
   assign b_sub = b_ff - c_ff - a_ff;
   assign c_sub = c_ff - a_ff - b_ff;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      step_in      = step_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_LOAD: begin
            if (q_valid) begin
               a_in      = base_a + q_job.word_a;
               b_in      = base_b + q_job.word_b;
               c_in      = base_c + q_job.word_c;
               kind_in   = q_job.kind;
               len_in    = q_job.length;
               second_in = 1'b0;
               step_in   = 4'd0;
               state_in  = ST_MIX;
            end
         end
         ST_MIX: begin
            case (step_ff)
               4'd0:    a_in = a_sub ^ (c_ff >> 13);
               4'd1:    b_in = b_sub ^ (a_ff << 8);
               4'd2:    c_in = c_sub ^ (b_ff >> 13);
               4'd3:    a_in = a_sub ^ (c_ff >> 12);
               4'd4:    b_in = b_sub ^ (a_ff << 16);
               4'd5:    c_in = c_sub ^ (b_ff >> 5);
               4'd6:    a_in = a_sub ^ (c_ff >> 3);
               4'd7:    b_in = b_sub ^ (a_ff << 10);
               4'd8:    c_in = c_sub ^ (b_ff >> 15);
               default: a_in = a_ff;
            endcase
            if (step_ff == LAST_STEP) begin
               if (kind_ff == JOB_BLOCK_TAIL && !second_ff) begin
                  state_in = ST_LEN;
               end else if (kind_ff == JOB_BLOCK) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_LEN: begin
            c_in      = c_ff + len_ff;
            second_in = 1'b1;
            step_in   = 4'd0;
            state_in  = ST_MIX;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = c_ff;
               state_in     = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         step_ff      <= 4'd0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      c_ff        <= c_in;
      kind_ff     <= kind_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ design/lookup2_byte_hash_core.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata[7:0] data_byte, tlast last_byte
// rsp_      out        rsp_tvalid/rsp_tready  tdata[31:0] hash_out
// csr_      in         csr_wr_en              csr_wr_data[31:0] init_value
//
// Bytes enter at one per cycle while the job queue is not full; each full block or
// message end queues a mix job. The back runs each job as a load plus 9 mix steps;
// a message that ends on a block boundary adds the length and mixes again, then posts the hash.
// Long messages sustain one byte a cycle; short ones are bounded by the back's mix loop.
// Reset is synchronous and clears control state; init_value resets to zero.
// req_tready drops only while the job queue is full; a stalled result holds in its register.

`default_nettype none

module lookup2_byte_hash_core
   import lbh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4   // 2 or more
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] data_byte
   input  wire logic        req_tlast,    // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [31:0] hash_out
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data   // [31:0] init_value
);

   logic [31:0] init_value_ff;
   logic        q_full, q_push, q_pop, q_valid;
   job_type     push_job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_value_ff <= 32'd0;
      end else if (csr_wr_en) begin
         init_value_ff <= csr_wr_data;
      end
   end

   lbh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   lbh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job)
   );

   lbh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .init_value (init_value_ff),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ design/lbh_checker.sv @@
`default_nettype none

module lbh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   logic [7:0] pending_ff, pending_in;
   logic       last_acc, rsp_acc;

   assign last_acc = req_tvalid && req_tready && req_tlast;
   assign rsp_acc  = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (last_acc && !rsp_acc) begin
         pending_in = pending_ff + 8'd1;
      end else if (rsp_acc && !last_acc) begin
         pending_in = pending_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 8'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_rsp_has_message: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 8'd0)
      else $error("result without a finished message");

endmodule

bind lookup2_byte_hash_core lbh_checker u_checker (.*);

`default_nettype wire
